// ===== rtl/core/mva_pkg.sv =====
// shared types and constants of the midi voice allocator
package mva_pkg;

   localparam logic [2:0] OP_NOTE_ON        = 3'd0;
   localparam logic [2:0] OP_NOTE_OFF       = 3'd1;
   localparam logic [2:0] OP_PEDAL_ON       = 3'd2;
   localparam logic [2:0] OP_PEDAL_OFF      = 3'd3;
   localparam logic [2:0] OP_ALL_NOTES_OFF  = 3'd4;
   localparam logic [2:0] OP_ALL_SOUND_OFF  = 3'd5;
   localparam logic [2:0] OP_VOICE_FINISHED = 3'd6;

   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_KILL    = 2'd2;

   localparam int NOTE_COUNT = 128;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] voice;
      logic [6:0] note;
      logic [6:0] velocity;
   } cmd_type;

endpackage

// ===== rtl/core/mva_out_buf.sv =====
// command holding stage and output register that marks the last command of a request
module mva_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  mva_pkg::cmd_type    push_data,
   output logic                push_ready,
   input  logic                fin_req,
   output logic                fin_done,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_command,
   output logic [3:0]          rsp_voice,
   output logic [6:0]          rsp_note_out,
   output logic [6:0]          rsp_velocity_out,
   output logic                rsp_last
);

   logic             hold_valid_ff, hold_valid_in;
   mva_pkg::cmd_type hold_ff, hold_in;
   logic             out_valid_ff, out_valid_in;
   mva_pkg::cmd_type out_ff, out_in;
   logic             last_ff, last_in;
   logic             can_move;

   assign can_move   = !out_valid_ff || rsp_ready;
   assign push_ready = !hold_valid_ff || can_move;
   assign fin_done   = fin_req && (!hold_valid_ff || can_move);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      last_in       = last_ff;
      if (push_valid && push_ready) begin
         if (hold_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = hold_ff;
            last_in      = 1'b0;
         end
         hold_valid_in = 1'b1;
         hold_in       = push_data;
      end else if (fin_req && hold_valid_ff && can_move) begin
         out_valid_in  = 1'b1;
         out_in        = hold_ff;
         last_in       = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      hold_ff <= hold_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_command      = out_ff.command;
   assign rsp_voice        = out_ff.voice;
   assign rsp_note_out     = out_ff.note;
   assign rsp_velocity_out = out_ff.velocity;
   assign rsp_last         = last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_ff))
      else $error("pending command overwritten");
   a_fin_drains: assert property (@(posedge clock) disable iff (reset)
      fin_done |=> !hold_valid_ff)
      else $error("held command left after finish");

endmodule

// ===== rtl/core/midi_voice_allocator_unit.sv =====
// Polyphonic voice allocator with oldest-voice stealing. One request is taken at a time and
// req_ready stays low until its last command has left the holding stage. A sequencer walks the
// voice table one voice per cycle through a single note/age comparator, stalling on a voice
// whose command waits. Note on: a release scan, then up to two allocation scans; note off with
// the pedal up, all notes off and all sound off: one scan each; pedal off: all 128 notes and
// one scan per sustained note. Each command waits for the output side to take the one before.
module midi_voice_allocator_unit #(
   parameter int NUM_VOICES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_polyphony,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_opcode,
   input  logic [6:0] req_note,
   input  logic [6:0] req_velocity,
   input  logic [3:0] req_voice_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_command,
   output logic [3:0] rsp_voice,
   output logic [6:0] rsp_note_out,
   output logic [6:0] rsp_velocity_out,
   output logic       rsp_last
);

   localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_REL   = 4'd1;
   localparam logic [3:0] S_PICK0 = 4'd2;
   localparam logic [3:0] S_PICK1 = 4'd3;
   localparam logic [3:0] S_START = 4'd4;
   localparam logic [3:0] S_PEDAL = 4'd5;
   localparam logic [3:0] S_ANO   = 4'd6;
   localparam logic [3:0] S_ASO   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;

   localparam logic [1:0] CTX_NOTE_ON  = 2'd0;
   localparam logic [1:0] CTX_NOTE_OFF = 2'd1;
   localparam logic [1:0] CTX_PEDAL    = 2'd2;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  ctx_ff, ctx_in;
   logic [6:0]  note_ff, note_in;
   logic [6:0]  vel_ff, vel_in;
   logic [VW-1:0] idx_ff, idx_in;
   logic [6:0]  nidx_ff, nidx_in;
   logic [VW-1:0] best_ff, best_in;
   logic        found_ff, found_in;
   logic [31:0] best_age_ff, best_age_in;
   logic [31:0] age_cnt_ff, age_cnt_in;
   logic [4:0]  poly_ff;
   logic        pedal_ff, pedal_in;
   logic [mva_pkg::NOTE_COUNT-1:0] sust_ff, sust_in;
   logic [NUM_VOICES-1:0] act_ff, act_in;
   logic [NUM_VOICES-1:0] rel_ff, rel_in;
   logic [6:0]  vnote_ff [NUM_VOICES];
   logic [31:0] vage_ff [NUM_VOICES];

   logic        wr_en;
   logic [VW-1:0] wr_idx;

   logic        push_valid, push_ready, fin_req, fin_done;
   mva_pkg::cmd_type push_data;

   logic [2:0]  eff_op;
   logic [6:0]  poly7, lim7;
   logic [VW-1:0] lim_last, vi_idx;
   logic        cur_act, cur_rel, older, end_all, end_lim, hit;
   logic [6:0]  cur_note;
   logic [31:0] cur_age;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);

   assign poly7    = 7'(poly_ff);
   assign lim7     = (poly7 == 7'd0) ? 7'd1 :
                     (poly7 > 7'(NUM_VOICES)) ? 7'(NUM_VOICES) : poly7;
   assign lim_last = VW'(lim7 - 7'd1);
   assign vi_idx   = VW'(req_voice_index);

   assign cur_act  = act_ff[idx_ff];
   assign cur_rel  = rel_ff[idx_ff];
   assign cur_note = vnote_ff[idx_ff];
   assign cur_age  = vage_ff[idx_ff];
   assign older    = !found_ff || (cur_age < best_age_ff);
   assign end_all  = (idx_ff == VW'(NUM_VOICES - 1));
   assign end_lim  = (idx_ff == lim_last);

   assign eff_op = (req_opcode == mva_pkg::OP_NOTE_ON && req_velocity == 7'd0) ?
                   mva_pkg::OP_NOTE_OFF : req_opcode;

   always_comb begin
      state_in    = state_ff;
      ctx_in      = ctx_ff;
      note_in     = note_ff;
      vel_in      = vel_ff;
      idx_in      = idx_ff;
      nidx_in     = nidx_ff;
      best_in     = best_ff;
      found_in    = found_ff;
      best_age_in = best_age_ff;
      age_cnt_in  = age_cnt_ff;
      pedal_in    = pedal_ff;
      sust_in     = sust_ff;
      act_in      = act_ff;
      rel_in      = rel_ff;
      wr_en       = 1'b0;
      wr_idx      = best_ff;
      push_valid  = 1'b0;
      push_data   = '{command: mva_pkg::CMD_RELEASE, voice: 4'(idx_ff),
                      note: 7'd0, velocity: 7'd0};
      fin_req     = 1'b0;
      hit         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               note_in = req_note;
               vel_in  = req_velocity;
               idx_in  = '0;
               case (eff_op)
                  mva_pkg::OP_NOTE_ON: begin
                     sust_in[req_note] = 1'b0;
                     ctx_in   = CTX_NOTE_ON;
                     state_in = S_REL;
                  end
                  mva_pkg::OP_NOTE_OFF: begin
                     ctx_in = CTX_NOTE_OFF;
                     if (pedal_ff) begin
                        sust_in[req_note] = 1'b1;
                        state_in = S_FIN;
                     end else begin
                        state_in = S_REL;
                     end
                  end
                  mva_pkg::OP_PEDAL_ON: begin
                     pedal_in = 1'b1;
                     state_in = S_FIN;
                  end
                  mva_pkg::OP_PEDAL_OFF: begin
                     pedal_in = 1'b0;
                     nidx_in  = '0;
                     ctx_in   = CTX_PEDAL;
                     state_in = S_PEDAL;
                  end
                  mva_pkg::OP_ALL_NOTES_OFF: begin
                     sust_in  = '0;
                     state_in = S_ANO;
                  end
                  mva_pkg::OP_ALL_SOUND_OFF: begin
                     sust_in  = '0;
                     state_in = S_ASO;
                  end
                  mva_pkg::OP_VOICE_FINISHED: begin
                     if (32'(req_voice_index) < NUM_VOICES) begin
                        act_in[vi_idx] = 1'b0;
                        rel_in[vi_idx] = 1'b0;
                     end
                     state_in = S_FIN;
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_REL, S_ANO, S_ASO: begin
            if (state_ff == S_ASO) begin
               hit = cur_act;
               push_data.command = mva_pkg::CMD_KILL;
            end else if (state_ff == S_ANO) begin
               hit = cur_act && !cur_rel;
            end else begin
               hit = cur_act && !cur_rel && (cur_note == note_ff);
            end
            push_valid = hit;
            if (!hit || push_ready) begin
               if (hit) begin
                  rel_in[idx_ff] = (state_ff != S_ASO);
                  if (state_ff == S_ASO) act_in[idx_ff] = 1'b0;
               end
               idx_in = idx_ff + VW'(1);
               if (end_all) begin
                  idx_in = '0;
                  if (state_ff != S_REL || ctx_ff == CTX_NOTE_OFF) begin
                     state_in = S_FIN;
                  end else if (ctx_ff == CTX_NOTE_ON) begin
                     found_in = 1'b0;
                     state_in = S_PICK0;
                  end else if (nidx_ff == 7'd127) begin
                     state_in = S_FIN;
                  end else begin
                     nidx_in  = nidx_ff + 7'd1;
                     state_in = S_PEDAL;
                  end
               end
            end
         end
         S_PEDAL: begin
            if (sust_ff[nidx_ff]) begin
               sust_in[nidx_ff] = 1'b0;
               note_in  = nidx_ff;
               idx_in   = '0;
               state_in = S_REL;
            end else if (nidx_ff == 7'd127) begin
               state_in = S_FIN;
            end else begin
               nidx_in = nidx_ff + 7'd1;
            end
         end
         S_PICK0: begin
            if (!cur_act) begin
               best_in  = idx_ff;
               state_in = S_START;
            end else begin
               if (cur_rel && older) begin
                  best_in     = idx_ff;
                  best_age_in = cur_age;
                  found_in    = 1'b1;
               end
               idx_in = idx_ff + VW'(1);
               if (end_lim) begin
                  idx_in = '0;
                  if (found_in) begin
                     state_in = S_START;
                  end else begin
                     state_in = S_PICK1;
                  end
               end
            end
         end
         S_PICK1: begin
            if (older) begin
               best_in     = idx_ff;
               best_age_in = cur_age;
               found_in    = 1'b1;
            end
            idx_in = idx_ff + VW'(1);
            if (end_lim) begin
               idx_in   = '0;
               state_in = S_START;
            end
         end
         S_START: begin
            push_valid = 1'b1;
            push_data  = '{command: mva_pkg::CMD_START, voice: 4'(best_ff),
                           note: note_ff, velocity: vel_ff};
            if (push_ready) begin
               age_cnt_in      = age_cnt_ff + 32'd1;
               act_in[best_ff] = 1'b1;
               rel_in[best_ff] = 1'b0;
               wr_en           = 1'b1;
               state_in        = S_FIN;
            end
         end
         S_FIN: begin
            fin_req = 1'b1;
            if (fin_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         age_cnt_ff <= '0;
         poly_ff    <= 5'd16;
         pedal_ff   <= 1'b0;
         sust_ff    <= '0;
         act_ff     <= '0;
         rel_ff     <= '0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         age_cnt_ff <= age_cnt_in;
         if (csr_valid) poly_ff <= csr_polyphony;
         pedal_ff   <= pedal_in;
         sust_ff    <= sust_in;
         act_ff     <= act_in;
         rel_ff     <= rel_in;
         found_ff   <= found_in;
      end
      ctx_ff      <= ctx_in;
      note_ff     <= note_in;
      vel_ff      <= vel_in;
      idx_ff      <= idx_in;
      nidx_ff     <= nidx_in;
      best_ff     <= best_in;
      best_age_ff <= best_age_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VOICES; i++) begin
            vnote_ff[i] <= '0;
            vage_ff[i]  <= '0;
         end
      end else if (wr_en) begin
         vnote_ff[wr_idx] <= note_ff;
         vage_ff[wr_idx]  <= age_cnt_in;
      end
   end

   mva_out_buf u_out_buf (
      .clock            (clock),
      .reset            (reset),
      .push_valid       (push_valid),
      .push_data        (push_data),
      .push_ready       (push_ready),
      .fin_req          (fin_req),
      .fin_done         (fin_done),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command      (rsp_command),
      .rsp_voice        (rsp_voice),
      .rsp_note_out     (rsp_note_out),
      .rsp_velocity_out (rsp_velocity_out),
      .rsp_last         (rsp_last)
   );

   a_start_sets_active: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> act_ff[$past(wr_idx)] && !rel_ff[$past(wr_idx)])
      else $error("started voice not active");
   a_releasing_is_active: assert property (@(posedge clock) disable iff (reset)
      (rel_ff & ~act_ff) == '0)
      else $error("releasing voice not active");

endmodule
